FILE: rtl/cct_pkg.sv
// Shared types, constants and mask tables for the cable continuity and short tester.
// Used by cct_seq and cable_continuity_short_tester_top; depends on nothing else.
package cct_pkg;

    localparam int TEST_STEPS = 8;
    localparam int STEP_W     = 3;

    localparam logic [7:0]  IN1_BASE      = 8'h3F;
    localparam logic [7:0]  IN2_BASE      = 8'h60;
    localparam logic [7:0]  OUT1_ALL      = 8'h1E;
    localparam logic [7:0]  OUT2_ALL      = 8'h1D;
    localparam logic [7:0]  SETTLE_RESET  = 8'd10;
    localparam logic [15:0] HOLDOFF_RESET = 16'd2000;

    localparam logic CFG_SETTLE  = 1'b0;
    localparam logic CFG_HOLDOFF = 1'b1;

    typedef struct packed {
        logic       start_n;
        logic [7:0] port_b_pins;
        logic [7:0] port_c_pins;
        logic [7:0] port_d_pins;
    } t_tick;

    typedef struct packed {
        logic [7:0] dir_c;
        logic [7:0] level_c;
        logic [7:0] dir_d;
        logic [7:0] level_d;
        logic       pass_lamp;
        logic       fail_lamp;
    } t_result;

    function automatic logic [7:0] drv1_mask(input logic [STEP_W-1:0] step);
        logic [7:0] m;
        unique case (step)
            3'd0:    m = 8'h02;
            3'd1:    m = 8'h04;
            3'd2:    m = 8'h08;
            3'd3:    m = 8'h10;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

    function automatic logic [7:0] drv2_mask(input logic [STEP_W-1:0] step);
        logic [7:0] m;
        unique case (step)
            3'd4:    m = 8'h01;
            3'd5:    m = 8'h04;
            3'd6:    m = 8'h08;
            3'd7:    m = 8'h10;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

    function automatic logic [7:0] rcv1_mask(input logic [STEP_W-1:0] step);
        logic [7:0] m;
        unique case (step)
            3'd1:    m = 8'h08;
            3'd2:    m = 8'h01;
            3'd3:    m = 8'h04;
            3'd4:    m = 8'h20;
            3'd5:    m = 8'h02;
            3'd6:    m = 8'h10;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

    function automatic logic [7:0] rcv2_mask(input logic [STEP_W-1:0] step);
        logic [7:0] m;
        unique case (step)
            3'd0:    m = 8'h40;
            3'd7:    m = 8'h20;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

endpackage

FILE: rtl/cct_seq.sv
// Test sequencer: phase, step, wait counter, pass flag, drive registers and lamps.
// Consumes one registered tick per enable and presents the updated result; uses cct_pkg.
module cct_seq
    import cct_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  t_tick       i_tick,
    input  logic [7:0]  i_settle,
    input  logic [15:0] i_holdoff,
    output t_result     o_res
);

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_SETTLE0 = 4'd1,
        PH_GAP     = 4'd2,
        PH_HIGH    = 4'd3,
        PH_LOW     = 4'd4,
        PH_RELEASE = 4'd5,
        PH_HOLDOFF = 4'd6
    } t_phase;

    t_phase            r_phase, n_phase;
    logic [STEP_W-1:0] r_step, n_step;
    logic [15:0]       r_wait, n_wait;
    logic              r_all_ok, n_all_ok;
    logic [7:0]        r_dir_c, n_dir_c, r_lvl_c, n_lvl_c;
    logic [7:0]        r_dir_d, n_dir_d, r_lvl_d, n_lvl_d;
    logic [1:0]        r_lamps, n_lamps;

    logic [15:0] w_settle_load;
    logic        w_wait_more;
    logic        w_last_step;
    logic [7:0]  w_d1, w_d2, w_r1, w_r2;
    logic [7:0]  w_pb, w_pc, w_pd;
    logic        w_hit, w_stray, w_readback, w_ok;

    assign w_settle_load = (i_settle == 8'd0) ? 16'd1 : {8'd0, i_settle};
    assign w_wait_more   = r_wait > 16'd1;
    assign w_last_step   = ({1'b0, r_step} + 4'd1) >= 4'(TEST_STEPS);
    assign w_d1 = drv1_mask(r_step);
    assign w_d2 = drv2_mask(r_step);
    assign w_r1 = rcv1_mask(r_step);
    assign w_r2 = rcv2_mask(r_step);
    assign w_pb = i_tick.port_b_pins;
    assign w_pc = i_tick.port_c_pins;
    assign w_pd = i_tick.port_d_pins;

    assign w_hit      = ((w_pb & IN1_BASE & w_r1) | (w_pc & IN2_BASE & w_r2)) != 8'd0;
    assign w_stray    = ((w_pb & IN1_BASE & ~w_r1) | (w_pc & IN2_BASE & ~w_r2)) != 8'd0;
    assign w_readback = ((w_pc & OUT1_ALL & ~w_d1) | (w_pd & OUT2_ALL & ~w_d2)) != 8'd0;
    assign w_ok       = w_hit && !w_stray && !w_readback;

    always_comb begin
        n_phase  = r_phase;
        n_step   = r_step;
        n_wait   = r_wait;
        n_all_ok = r_all_ok;
        n_dir_c  = r_dir_c;
        n_lvl_c  = r_lvl_c;
        n_dir_d  = r_dir_d;
        n_lvl_d  = r_lvl_d;
        n_lamps  = r_lamps;

        if (r_phase == PH_SETTLE0 || r_phase == PH_GAP || r_phase == PH_HIGH
                || r_phase == PH_LOW || r_phase == PH_HOLDOFF) begin
            n_wait = w_wait_more ? (r_wait - 16'd1) : 16'd0;
        end

        unique case (r_phase)
            PH_IDLE: begin
                if (!i_tick.start_n) begin
                    n_lvl_c = 8'd0;
                    n_lvl_d = 8'd0;
                    n_wait  = w_settle_load;
                    n_phase = PH_SETTLE0;
                end
            end
            PH_SETTLE0: begin
                if (!w_wait_more) begin
                    if (((w_pb & IN1_BASE) | (w_pc & IN2_BASE)) != 8'd0) begin
                        n_lamps = 2'b11;
                        n_phase = PH_RELEASE;
                    end else begin
                        n_all_ok = 1'b1;
                        n_step   = '0;
                        n_wait   = w_settle_load;
                        n_phase  = PH_GAP;
                    end
                end
            end
            PH_GAP: begin
                if (!w_wait_more) begin
                    n_dir_c = w_d1;
                    n_lvl_c = w_d1;
                    n_dir_d = w_d2;
                    n_lvl_d = w_d2;
                    n_wait  = w_settle_load;
                    n_phase = PH_HIGH;
                end
            end
            PH_HIGH, PH_LOW: begin
                if (!w_wait_more) begin
                    if (r_phase == PH_HIGH && w_ok) begin
                        n_dir_c = OUT1_ALL;
                        n_lvl_c = OUT1_ALL & ~w_d1;
                        n_dir_d = OUT2_ALL;
                        n_lvl_d = OUT2_ALL & ~w_d2;
                        n_wait  = w_settle_load;
                        n_phase = PH_LOW;
                    end else begin
                        if (r_phase == PH_HIGH || w_hit) begin
                            n_all_ok = 1'b0;
                        end
                        if (w_last_step) begin
                            n_lamps = n_all_ok ? 2'b01 : 2'b10;
                            n_phase = PH_RELEASE;
                        end else begin
                            n_step  = r_step + 3'd1;
                            n_wait  = w_settle_load;
                            n_phase = PH_GAP;
                        end
                    end
                end
            end
            PH_RELEASE: begin
                if (i_tick.start_n) begin
                    n_lamps = 2'b00;
                    n_wait  = (i_holdoff == 16'd0) ? 16'd1 : i_holdoff;
                    n_phase = PH_HOLDOFF;
                end
            end
            PH_HOLDOFF: begin
                if (!w_wait_more) begin
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_step   <= '0;
            r_wait   <= 16'd0;
            r_all_ok <= 1'b1;
            r_dir_c  <= 8'd0;
            r_lvl_c  <= 8'd0;
            r_dir_d  <= 8'd0;
            r_lvl_d  <= 8'd0;
            r_lamps  <= 2'b00;
        end else if (i_en) begin
            r_phase  <= n_phase;
            r_step   <= n_step;
            r_wait   <= n_wait;
            r_all_ok <= n_all_ok;
            r_dir_c  <= n_dir_c;
            r_lvl_c  <= n_lvl_c;
            r_dir_d  <= n_dir_d;
            r_lvl_d  <= n_lvl_d;
            r_lamps  <= n_lamps;
        end
    end

    assign o_res.dir_c     = n_dir_c;
    assign o_res.level_c   = n_lvl_c;
    assign o_res.dir_d     = n_dir_d;
    assign o_res.level_d   = n_lvl_d;
    assign o_res.pass_lamp = n_lamps[0];
    assign o_res.fail_lamp = n_lamps[1];

    a_idle_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_IDLE |-> r_lamps == 2'b00)
        else $error("lamps lit while idle");

    a_hold_when_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(r_phase) && $stable(r_step) && $stable(r_wait))
        else $error("sequencer moved without a tick");

    a_step_only_in_test: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && (r_phase == PH_IDLE || r_phase == PH_HOLDOFF)) |=> $stable(r_step))
        else $error("step index changed outside the test run");

endmodule

FILE: rtl/cable_continuity_short_tester_top.sv
// Top level of the cable continuity and short tester: input register, sequencer, result register.
// Instantiates cct_seq; uses cct_pkg.
//
//  Channel | Direction | Handshake                  | Payload
//  --------+-----------+----------------------------+------------------------------------------
//  in      | in        | i_in_valid / o_in_stall    | i_start_n, i_port_b/c/d_pins
//  out     | out       | o_out_valid / i_out_stall  | o_dir_c, o_level_c, o_dir_d, o_level_d, lamps
//  cfg     | in        | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// One beat is accepted per cycle while o_in_stall is low; each produces one result beat.
// The input register feeds the sequencer update, which is written into the result register.
// Synchronous active-low reset clears the sequencer and the pipeline valid flags and loads the reset configuration.
// A stall on the output holds the result register and then the input register in turn.
module cable_continuity_short_tester_top
    import cct_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_start_n,
    input  logic [7:0]  i_port_b_pins,
    input  logic [7:0]  i_port_c_pins,
    input  logic [7:0]  i_port_d_pins,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_dir_c,
    output logic [7:0]  o_level_c,
    output logic [7:0]  o_dir_d,
    output logic [7:0]  o_level_d,
    output logic        o_pass_lamp,
    output logic        o_fail_lamp,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic        r_s1_valid;
    t_tick       r_s1_tick;
    logic        r_out_valid;
    t_result     r_out;
    logic [7:0]  r_settle;
    logic [15:0] r_holdoff;

    logic    w_out_free;
    logic    w_s1_adv;
    logic    w_in_acc;
    t_result w_res;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_s1_adv   = r_s1_valid && w_out_free;
    assign o_in_stall = r_s1_valid && !w_out_free;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle  <= SETTLE_RESET;
            r_holdoff <= HOLDOFF_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SETTLE:  r_settle  <= i_cfg_data[7:0];
                CFG_HOLDOFF: r_holdoff <= i_cfg_data;
                default:     r_settle  <= r_settle;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_tick.start_n     <= i_start_n;
            r_s1_tick.port_b_pins <= i_port_b_pins;
            r_s1_tick.port_c_pins <= i_port_c_pins;
            r_s1_tick.port_d_pins <= i_port_d_pins;
        end
    end

    cct_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_s1_adv),
        .i_tick    (r_s1_tick),
        .i_settle  (r_settle),
        .i_holdoff (r_holdoff),
        .o_res     (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_s1_adv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_dir_c     = r_out.dir_c;
    assign o_level_c   = r_out.level_c;
    assign o_dir_d     = r_out.dir_d;
    assign o_level_d   = r_out.level_d;
    assign o_pass_lamp = r_out.pass_lamp;
    assign o_fail_lamp = r_out.fail_lamp;

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_valid && r_out_valid)
        else $error("input stalled with no beat in flight");

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_s1_valid)
        else $error("accepted beat lost from input register");

    a_advance_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_adv |=> r_out_valid)
        else $error("sequencer update produced no result beat");

endmodule

FILE: dv/tb_cable_continuity_short_tester_top.sv
// Self-checking testbench for cable_continuity_short_tester_top: random and directed timer ticks
// are checked against an in-bench model of the wire-test sequencer.
// Depends on rtl/cct_pkg.sv and rtl/cable_continuity_short_tester_top.sv.
`timescale 1ns / 1ps

module tb_cable_continuity_short_tester_top;
    import cct_pkg::*;

    localparam int LONG_HOLD      = 80;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int REPORT_LIMIT   = 10;

    localparam logic [63:0] DRV1_TAB = 64'h00000000_10080402;
    localparam logic [63:0] DRV2_TAB = 64'h10080401_00000000;
    localparam logic [63:0] RCV1_TAB = 64'h00100220_04010800;
    localparam logic [63:0] RCV2_TAB = 64'h20000000_00000040;

    typedef enum logic [3:0] {
        SQ_IDLE, SQ_SETTLE, SQ_GAP, SQ_HIGH, SQ_LOW, SQ_RELEASE, SQ_HOLDOFF
    } t_seq_phase;

    typedef enum logic [1:0] {PLAN_RAW, PLAN_GOOD, PLAN_NEAR, PLAN_NOISE} t_plan_kind;

    typedef struct packed {
        t_plan_kind  kind;
        logic        start_n;
        logic [23:0] pins;
    } t_tick_plan;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    t_tick       tick = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  dir_c, level_c, dir_d, level_d;
    logic        pass_lamp, fail_lamp;
    logic        cfg_we = 1'b0;
    logic        cfg_index = CFG_SETTLE;
    logic [15:0] cfg_data = '0;

    t_tick_plan tick_plans[$];
    t_result    expected_outputs[$];

    int plans_total = 0;
    int results_seen = 0;
    int mismatches = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int long_hold_ask = 0;
    int long_hold_seen = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int runs_passed = 0;
    int runs_failed = 0;
    int idle_faults = 0;

    t_seq_phase  seq_phase = SQ_IDLE;
    logic [2:0]  seq_step = '0;
    logic [15:0] seq_wait = '0;
    logic        seq_all_ok = 1'b1;
    logic [7:0]  dir_c_r = '0, lvl_c_r = '0, dir_d_r = '0, lvl_d_r = '0;
    logic [1:0]  lamp_r = '0;
    logic [7:0]  cfg_settle = SETTLE_RESET;
    logic [15:0] cfg_holdoff = HOLDOFF_RESET;

    cable_continuity_short_tester_top uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_start_n     (tick.start_n),
        .i_port_b_pins (tick.port_b_pins),
        .i_port_c_pins (tick.port_c_pins),
        .i_port_d_pins (tick.port_d_pins),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_dir_c       (dir_c),
        .o_level_c     (level_c),
        .o_dir_d       (dir_d),
        .o_level_d     (level_d),
        .o_pass_lamp   (pass_lamp),
        .o_fail_lamp   (fail_lamp),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [15:0] settle_count();
        return (cfg_settle == 8'd0) ? 16'd1 : {8'd0, cfg_settle};
    endfunction

    // Counts one tick of a wait; returns 0 on the final tick, which samples the pins.
    function automatic logic wait_more();
        if (seq_wait > 16'd1) begin
            seq_wait = seq_wait - 16'd1;
            return 1'b1;
        end
        seq_wait = '0;
        return 1'b0;
    endfunction

    function automatic void finish_step();
        if (int'(seq_step) + 1 >= TEST_STEPS) begin
            lamp_r = seq_all_ok ? 2'b01 : 2'b10;
            if (seq_all_ok) begin
                runs_passed++;
            end else begin
                runs_failed++;
            end
            seq_phase = SQ_RELEASE;
        end else begin
            seq_step = seq_step + 3'd1;
            seq_wait = settle_count();
            seq_phase = SQ_GAP;
        end
    endfunction

    function automatic t_result advance_sequencer(input t_tick tk);
        logic [7:0] d1, d2, r1, r2, pb, pc, pd;
        logic       ok;
        t_result    r;
        d1 = DRV1_TAB[{seq_step, 3'b000} +: 8];
        d2 = DRV2_TAB[{seq_step, 3'b000} +: 8];
        r1 = RCV1_TAB[{seq_step, 3'b000} +: 8];
        r2 = RCV2_TAB[{seq_step, 3'b000} +: 8];
        pb = tk.port_b_pins;
        pc = tk.port_c_pins;
        pd = tk.port_d_pins;
        case (seq_phase)
            SQ_IDLE: begin
                if (!tk.start_n) begin
                    lvl_c_r = '0;
                    lvl_d_r = '0;
                    seq_wait = settle_count();
                    seq_phase = SQ_SETTLE;
                end
            end
            SQ_SETTLE: begin
                if (!wait_more()) begin
                    if (((pb & IN1_BASE) | (pc & IN2_BASE)) != 8'd0) begin
                        lamp_r = 2'b11;
                        idle_faults++;
                        seq_phase = SQ_RELEASE;
                    end else begin
                        seq_all_ok = 1'b1;
                        seq_step = '0;
                        seq_wait = settle_count();
                        seq_phase = SQ_GAP;
                    end
                end
            end
            SQ_GAP: begin
                if (!wait_more()) begin
                    dir_c_r = d1;
                    lvl_c_r = d1;
                    dir_d_r = d2;
                    lvl_d_r = d2;
                    seq_wait = settle_count();
                    seq_phase = SQ_HIGH;
                end
            end
            SQ_HIGH: begin
                if (!wait_more()) begin
                    ok = ((pb & IN1_BASE & r1) | (pc & IN2_BASE & r2)) != 8'd0;
                    if (((pb & IN1_BASE & ~r1) | (pc & IN2_BASE & ~r2)) != 8'd0)
                        ok = 1'b0;
                    if (((pc & OUT1_ALL & ~d1) | (pd & OUT2_ALL & ~d2)) != 8'd0)
                        ok = 1'b0;
                    if (!ok) begin
                        seq_all_ok = 1'b0;
                        finish_step();
                    end else begin
                        dir_c_r = OUT1_ALL;
                        lvl_c_r = OUT1_ALL & ~d1;
                        dir_d_r = OUT2_ALL;
                        lvl_d_r = OUT2_ALL & ~d2;
                        seq_wait = settle_count();
                        seq_phase = SQ_LOW;
                    end
                end
            end
            SQ_LOW: begin
                if (!wait_more()) begin
                    if (((pb & IN1_BASE & r1) | (pc & IN2_BASE & r2)) != 8'd0)
                        seq_all_ok = 1'b0;
                    finish_step();
                end
            end
            SQ_RELEASE: begin
                if (tk.start_n) begin
                    lamp_r = 2'b00;
                    seq_wait = (cfg_holdoff == 16'd0) ? 16'd1 : cfg_holdoff;
                    seq_phase = SQ_HOLDOFF;
                end
            end
            SQ_HOLDOFF: begin
                if (!wait_more()) seq_phase = SQ_IDLE;
            end
            default: seq_phase = SQ_IDLE;
        endcase
        r = {dir_c_r, lvl_c_r, dir_d_r, lvl_d_r, lamp_r[0], lamp_r[1]};
        return r;
    endfunction

    // Turns a plan into pin levels; well-formed plans pass the check the sequencer makes next.
    function automatic t_tick shape_tick(input t_tick_plan p);
        t_tick      t;
        logic [7:0] d1, d2, r1, r2;
        d1 = DRV1_TAB[{seq_step, 3'b000} +: 8];
        d2 = DRV2_TAB[{seq_step, 3'b000} +: 8];
        r1 = RCV1_TAB[{seq_step, 3'b000} +: 8];
        r2 = RCV2_TAB[{seq_step, 3'b000} +: 8];
        t.start_n = p.start_n;
        t.port_b_pins = 8'($urandom);
        t.port_c_pins = 8'($urandom);
        t.port_d_pins = 8'($urandom);
        if (p.kind == PLAN_RAW) begin
            t[23:0] = p.pins;
        end else if (p.kind != PLAN_NOISE) begin
            case (seq_phase)
                SQ_SETTLE: begin
                    t.port_b_pins = t.port_b_pins & ~IN1_BASE;
                    t.port_c_pins = t.port_c_pins & ~IN2_BASE;
                end
                SQ_HIGH: begin
                    t.port_b_pins = (t.port_b_pins & ~IN1_BASE) | r1;
                    t.port_c_pins = (t.port_c_pins & ~(IN2_BASE | OUT1_ALL)) | r2
                                    | (t.port_c_pins & d1);
                    t.port_d_pins = (t.port_d_pins & ~OUT2_ALL) | (t.port_d_pins & d2);
                end
                SQ_LOW: begin
                    t.port_b_pins = t.port_b_pins & ~r1;
                    t.port_c_pins = t.port_c_pins & ~r2;
                end
                default: ;
            endcase
            if (p.kind == PLAN_NEAR) t[23:0] = t[23:0] ^ (24'd1 << $urandom_range(23, 0));
        end
        return t;
    endfunction

    always @(posedge clk) begin : drive_ticks
        t_tick      nxt_tick;
        logic       nxt_valid;
        t_tick_plan p;
        nxt_tick = tick;
        nxt_valid = in_valid;
        if (!rst_n) begin
            nxt_valid = 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                expected_outputs.push_back(advance_sequencer(tick));
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && tick_plans.size() != 0
                    && $urandom_range(99, 0) >= send_idle_pct) begin
                p = tick_plans.pop_front();
                nxt_tick = shape_tick(p);
                nxt_valid = 1'b1;
            end
        end
        in_valid <= nxt_valid;
        tick <= nxt_tick;
    end

    always @(posedge clk) begin : drive_stall
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (long_hold_ask != long_hold_seen) begin
            long_hold_seen++;
            hold_left = LONG_HOLD - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
        end
    end

    // Each report line shows dir/level for port C, then for port D, then the lamps.
    always @(posedge clk) begin : check_outputs
        t_result got, want;
        if (rst_n && out_valid && !out_stall) begin
            got = {dir_c, level_c, dir_d, level_d, pass_lamp, fail_lamp};
            results_seen++;
            if (expected_outputs.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("result %0d arrived with no tick waiting for it", results_seen);
            end else begin
                want = expected_outputs.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("result %0d: want C %h/%h D %h/%h pass %b fail %b",
                                 results_seen, want.dir_c, want.level_c, want.dir_d,
                                 want.level_d, want.pass_lamp, want.fail_lamp);
                        $display("           got  C %h/%h D %h/%h pass %b fail %b",
                                 got.dir_c, got.level_c, got.dir_d, got.level_d,
                                 got.pass_lamp, got.fail_lamp);
                    end
                end
            end
        end
    end

    always @(posedge clk) begin : watchdog
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("No beat moved for %0d cycles.", quiet_cycles);
            $display("cable_continuity_short_tester_top: mismatch");
            $finish;
        end
    end

    task automatic write_reg(input logic idx, input logic [15:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == CFG_SETTLE) begin
            cfg_settle = val[7:0];
        end else begin
            cfg_holdoff = val;
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic add_plan(input t_plan_kind kind, input logic start_n, input logic [23:0] pins);
        t_tick_plan p;
        p.kind = kind;
        p.start_n = start_n;
        p.pins = pins;
        tick_plans.push_back(p);
        plans_total++;
    endtask

    task automatic drain_block();
        while (results_seen < plans_total) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_phase(input int settle, input int holdoff, input int idle_pct,
                             input int stall_pct, input int err_pct, input int count,
                             input bit long_hold);
        int         r;
        t_plan_kind kind;
        write_reg(CFG_SETTLE, settle[15:0]);
        write_reg(CFG_HOLDOFF, holdoff[15:0]);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < count; n++) begin
            if (n == count / 2) drain_block();
            r = $urandom_range(99, 0);
            if (r < err_pct / 2) begin
                kind = PLAN_NEAR;
            end else if (r < err_pct) begin
                kind = PLAN_NOISE;
            end else begin
                kind = PLAN_GOOD;
            end
            add_plan(kind, 1'($urandom_range(1, 0)), 24'h0);
            if (n == 0 && long_hold) long_hold_ask++;
        end
        drain_block();
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero wait registers behave as one tick.
        write_reg(CFG_SETTLE, 16'd0);
        write_reg(CFG_HOLDOFF, 16'd0);

        // The idle check fails, start is held through release, then the hold-off ignores start.
        add_plan(PLAN_RAW, 1'b1, 24'h000000);
        add_plan(PLAN_RAW, 1'b0, 24'hFFFFFF);
        add_plan(PLAN_RAW, 1'b1, 24'hFFFFFF);
        add_plan(PLAN_RAW, 1'b0, 24'h000000);
        add_plan(PLAN_RAW, 1'b1, 24'h000000);
        add_plan(PLAN_RAW, 1'b0, 24'hFFFFFF);
        // A run with a failed low check, a missing wire, a short and a bad readback.
        add_plan(PLAN_RAW, 1'b0, 24'hFFFFFF);
        add_plan(PLAN_RAW, 1'b0, 24'hC09FFF);
        add_plan(PLAN_GOOD, 1'b0, 24'h0);
        add_plan(PLAN_GOOD, 1'b0, 24'h0);
        add_plan(PLAN_RAW, 1'b1, 24'hFFFFFF);
        add_plan(PLAN_GOOD, 1'b1, 24'h0);
        add_plan(PLAN_RAW, 1'b1, 24'h000000);
        add_plan(PLAN_GOOD, 1'b1, 24'h0);
        add_plan(PLAN_RAW, 1'b1, 24'h030000);
        add_plan(PLAN_GOOD, 1'b1, 24'h0);
        add_plan(PLAN_RAW, 1'b1, 24'h041200);
        repeat (12) add_plan(PLAN_GOOD, 1'b1, 24'h0);
        add_plan(PLAN_GOOD, 1'b0, 24'h0);
        add_plan(PLAN_GOOD, 1'b1, 24'h0);
        add_plan(PLAN_GOOD, 1'b0, 24'h0);
        drain_block();

        run_phase(1, 1, 0, 0, 0, 250, 1'b0);
        run_phase(255, 3, 50, 0, 5, 400, 1'b0);
        run_phase(2, 5, 0, 50, 5, 250, 1'b1);
        run_phase(3, 17, 17, 17, 10, 250, 1'b0);
        run_phase($urandom_range(4, 1), $urandom_range(40, 1), 0, 0, 30, 250, 1'b0);
        run_phase(1, 65535, 50, 50, 0, 250, 1'b0);

        repeat (8) @(posedge clk);
        if (expected_outputs.size() != 0) begin
            mismatches += expected_outputs.size();
            $display("%0d expected results never arrived", expected_outputs.size());
        end
        $display("Sent %0d ticks through directed cases and six register settings under idle,",
                 plans_total);
        $display("stall and back-pressure: %0d passing runs, %0d failing runs, %0d idle faults.",
                 runs_passed, runs_failed, idle_faults);
        if (mismatches == 0) begin
            $display("cable_continuity_short_tester_top: match");
        end else begin
            $display("cable_continuity_short_tester_top: mismatch");
        end
        $finish;
    end

endmodule
